// ===== sv/bbs_pkg.sv =====
`timescale 1ns / 1ps

package bbs_pkg;

  // Element width and depth of the queue between the front and the back.
  localparam int unsigned DataW      = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // One queued beat: the value and whether it completes the set.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } queue_item_t;

  // Sequencer states of the back part.
  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_READ = 5'b00010,
    ST_LOW  = 5'b00100,
    ST_HIGH = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_e;

endpackage

// ===== sv/bbs_ram.sv =====
`timescale 1ns / 1ps

module bbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== sv/bbs_front.sv =====
`timescale 1ns / 1ps

module bbs_front
  import bbs_pkg::*;
#(
  parameter int unsigned SetSize = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    busy_o,
  input  logic                    pop_i,
  output queue_item_t             item_o,
  output logic                    item_valid_o
);

  localparam int unsigned CntW = $clog2(SetSize);

  logic [CntW-1:0]  load_cnt_q, load_cnt_d;
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   fill_q, fill_d;
  queue_item_t      queue_q [QueueDepth];
  logic             accept;
  logic             set_last;

  // The front takes a beat whenever the queue has room.
  assign busy_o       = (fill_q == (QPtrW+1)'(QueueDepth));
  assign accept       = start_i & ~busy_o;
  assign item_valid_o = (fill_q != '0);
  assign item_o       = queue_q[rd_ptr_q];

  // Tag the beat that completes the set.
  assign set_last = (load_cnt_q == CntW'(SetSize - 1));

  always_comb begin
    load_cnt_d = load_cnt_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    if (accept) begin
      load_cnt_d = set_last ? '0 : load_cnt_q + CntW'(1);
      wr_ptr_d   = wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    fill_d = fill_q + (QPtrW+1)'(accept) - (QPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fill_q     <= '0;
    end else begin
      load_cnt_q <= load_cnt_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      fill_q     <= fill_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wr_ptr_q] <= '{value: value_i, last: set_last};
    end
  end

endmodule

// ===== sv/bbs_back.sv =====
`timescale 1ns / 1ps

module bbs_back
  import bbs_pkg::*;
#(
  parameter int unsigned SetSize = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  queue_item_t             item_i,
  input  logic                    item_valid_i,
  output logic                    pop_o,
  output logic                    result_valid_o,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    is_last_o
);

  // The set is padded to a power of two; padded places act as +infinity.
  localparam int unsigned Lg      = $clog2(SetSize);
  localparam int unsigned AddrW   = Lg;
  localparam int unsigned PadHalf = (1 << Lg) / 2;
  localparam int unsigned KW      = $clog2(Lg + 1);

  back_state_e      state_q, state_d;
  logic [KW-1:0]    k_q, k_d;
  logic [KW-1:0]    j_q, j_d;
  logic [AddrW-1:0] c_q, c_d;
  logic [AddrW-1:0] wa_q, wa_d;
  logic [AddrW-1:0] oa_q, oa_d;
  logic             pend_q, pend_d;
  logic             last_q, last_d;
  logic [DataW-1:0] hi_q, hi_d;

  logic [AddrW-1:0] low_mask, k_mask, lo_idx, hi_idx;
  logic             first_sub, in_range, last_cmp, last_sub, last_stage;
  logic             we;
  logic [AddrW-1:0] waddr, raddr_a;
  logic [DataW-1:0] wdata, rdata_a, rdata_b, min_val;
  logic             swap;

  bbs_ram #(
    .Width (DataW),
    .Depth (SetSize)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (hi_idx),
    .rdata_b_o (rdata_b)
  );

  // Comparator indices: insert a zero at bit j of the counter for the low
  // side; the first substage of a merge mirrors the block, the others add 2^j.
  always_comb begin
    low_mask   = ~({AddrW{1'b1}} << j_q);
    k_mask     = ~({AddrW{1'b1}} << k_q);
    lo_idx     = ((c_q & ~low_mask) << 1) | (c_q & low_mask);
    first_sub  = ((j_q + KW'(1)) == k_q);
    hi_idx     = first_sub ? (lo_idx ^ k_mask) : (lo_idx | (AddrW'(1) << j_q));
    in_range   = ({1'b0, hi_idx} < (AddrW+1)'(SetSize));
    last_cmp   = (c_q == AddrW'(PadHalf - 1));
    last_sub   = (j_q == '0);
    last_stage = (k_q == KW'(Lg));
  end

  // Every comparator leaves the smaller value at the lower index.
  assign swap    = ($signed(rdata_a) > $signed(rdata_b));
  assign min_val = swap ? rdata_b : rdata_a;
  assign raddr_a = (state_q == ST_OUT) ? oa_q : lo_idx;

  // Output beats come straight from the registered read port.
  assign result_valid_o = pend_q;
  assign is_last_o      = last_q;
  assign sorted_value_o = rdata_a;

  // Sequencer: load, then compare-exchange over all stages, then stream out.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    j_d     = j_q;
    c_d     = c_q;
    wa_d    = wa_q;
    oa_d    = oa_q;
    hi_d    = hi_q;
    pend_d  = 1'b0;
    last_d  = 1'b0;
    pop_o   = 1'b0;
    we      = 1'b0;
    waddr   = wa_q;
    wdata   = item_i.value;

    case (state_q)
      ST_LOAD: begin
        if (item_valid_i) begin
          pop_o = 1'b1;
          we    = 1'b1;
          if (item_i.last) begin
            wa_d    = '0;
            k_d     = KW'(1);
            j_d     = '0;
            c_d     = '0;
            state_d = ST_READ;
          end else begin
            wa_d = wa_q + AddrW'(1);
          end
        end
      end
      ST_READ: begin
        if (in_range) begin
          state_d = ST_LOW;
        end
      end
      ST_LOW: begin
        we      = 1'b1;
        waddr   = lo_idx;
        wdata   = min_val;
        hi_d    = swap ? rdata_a : rdata_b;
        state_d = ST_HIGH;
      end
      ST_HIGH: begin
        we    = 1'b1;
        waddr = hi_idx;
        wdata = hi_q;
      end
      ST_OUT: begin
        pend_d = 1'b1;
        last_d = (oa_q == AddrW'(SetSize - 1));
        if (last_d) begin
          state_d = ST_LOAD;
        end else begin
          oa_d = oa_q + AddrW'(1);
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // Step to the next comparator after a write-back or a padded pair.
    if ((state_q == ST_HIGH) || ((state_q == ST_READ) && !in_range)) begin
      state_d = ST_READ;
      if (last_cmp) begin
        c_d = '0;
        if (last_sub) begin
          if (last_stage) begin
            oa_d    = '0;
            state_d = ST_OUT;
          end else begin
            k_d = k_q + KW'(1);
            j_d = k_q;
          end
        end else begin
          j_d = j_q - KW'(1);
        end
      end else begin
        c_d = c_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      k_q     <= '0;
      j_q     <= '0;
      c_q     <= '0;
      wa_q    <= '0;
      oa_q    <= '0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      j_q     <= j_d;
      c_q     <= c_d;
      wa_q    <= wa_d;
      oa_q    <= oa_d;
      pend_q  <= pend_d;
      last_q  <= last_d;
    end
  end

  // The larger value is held in a register for the write port in ST_HIGH.
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
  end

endmodule

// ===== sv/block_bitonic_sorter_unit.sv =====
`timescale 1ns / 1ps

// Channel   Ports                              Beat taken when
// input     start, value_i, busy               start high and busy low
// result    result_valid_o, sorted_value_o,    every cycle result_valid_o is high
//           is_last_o
//
// Items enter a four-deep queue and are written to the element memory one per
// cycle while the back is loading. The beat that completes a set of N =
// NUM_BLOCKS*BLOCK_LEN values starts the sort: Lg*(Lg+1)/2 stages (Lg = clog2(N))
// of 2^(Lg-1) comparators, each a read and then a low and a high write-back on the
// memory's single write port, or only the read where the pair falls in the padding.
// Then N results stream out on consecutive cycles. Reset clears all control;
// busy stays high while the queue is full. Results cannot be stalled.
module block_bitonic_sorter_unit
  import bbs_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 4,
  parameter int unsigned BLOCK_LEN  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic signed [DataW-1:0] value_i,
  output logic                    busy,
  output logic                    result_valid_o,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    is_last_o
);

  localparam int unsigned SetSize = NUM_BLOCKS * BLOCK_LEN;

  queue_item_t item;
  logic        item_valid;
  logic        pop;

  bbs_front #(
    .SetSize (SetSize)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .value_i      (value_i),
    .busy_o       (busy),
    .pop_i        (pop),
    .item_o       (item),
    .item_valid_o (item_valid)
  );

  bbs_back #(
    .SetSize (SetSize)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .item_valid_i   (item_valid),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .sorted_value_o (sorted_value_o),
    .is_last_o      (is_last_o)
  );

  // The last mark only rides on a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_last_o |-> result_valid_o)
    else $error("is_last_o without a result beat");

  // A sorted run streams without gaps until its last beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !is_last_o) |=> result_valid_o)
    else $error("gap inside a sorted run");

  // A new run never follows the previous one directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_last_o |=> !result_valid_o)
    else $error("result beat right after the last of a run");

  // The back only drains the queue when it holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> item_valid)
    else $error("pop from an empty queue");

endmodule
